### sv/emp_pkg.sv
// Shared package for the extremum picker with minimum spacing.
// Holds parameter defaults, register indexes and control structs.
// No dependencies.
`timescale 1ns / 1ps

package emp_pkg;

    // Defaults for the top-level parameters.
    localparam int MIN_SPACE_DEF   = 9;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CUTOFF_W   = 16;
    localparam int LENGTH_W   = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF  = 2'd0,
        CFG_VALLEYS = 2'd1,
        CFG_LENGTH  = 2'd2
    } t_cfg_idx;

    // Decision for one accepted sample.
    typedef struct packed {
        logic last;   // sample ends the list
        logic emit;   // held extremum is sent out (not at list end)
        logic take;   // candidate becomes (or replaces) the held extremum
    } t_step;

    // Flags that travel with one result word.
    typedef struct packed {
        logic found;  // index and value are meaningful
        logic eol;    // result given at the list's last sample
    } t_res_ctl;

endpackage

### sv/extremum_picker_min_spacing.sv
// Top level of the extremum picker with minimum spacing.
// Depends on emp_pkg, emp_core (with emp_judge) and emp_skid.
//
//   Channel   Direction  Handshake                Payload
//   s_*       in         i_s_tvalid / o_s_tready  tdata: sample
//   m_*       out        o_m_tvalid / i_m_tready  tdata: peak_index, peak_value;
//                                                 tuser: peak_found; tlast: end_of_list
//   cfg_*     in         i_cfg_valid/o_cfg_ready  index, data
//
// One sample is accepted per cycle while o_s_tready is high; its result word,
// if any, goes to the output register, or to the skid stage while stalled.
// The judgment compares the new sample, window registers and held extremum.
// Reset (synchronous, active low) clears the window, counter, held extremum
// and registers to their defaults. A stalled output parks one word in the
// skid stage; o_s_tready drops only while that stage is full.
`timescale 1ns / 1ps

module extremum_picker_min_spacing #(
    parameter int MIN_SPACE   = emp_pkg::MIN_SPACE_DEF,
    parameter int SAMPLE_BITS = emp_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = emp_pkg::INDEX_BITS_DEF,
    localparam int IN_TW  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((INDEX_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [IN_TW-1:0]                  i_s_tdata,   // [0+] sample
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [OUT_TW-1:0]                 o_m_tdata,   // [0+] peak_index, then peak_value
    output logic                              o_m_tuser,   // [0] peak_found
    output logic                              o_m_tlast,   // end_of_list
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [emp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [emp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CTL_W = $bits(emp_pkg::t_res_ctl);
    localparam int DW    = CTL_W + SAMPLE_BITS + INDEX_BITS;

    logic signed [emp_pkg::CUTOFF_W-1:0] r_cutoff;
    logic                                r_valleys;
    logic        [emp_pkg::LENGTH_W-1:0] r_length;

    logic                          fire;
    logic                          res_valid;
    logic        [INDEX_BITS-1:0]  res_index;
    logic signed [SAMPLE_BITS-1:0] res_value;
    emp_pkg::t_res_ctl             res_ctl;
    emp_pkg::t_res_ctl             out_ctl;
    logic        [DW-1:0]          buf_in;
    logic        [DW-1:0]          buf_out;
    logic                          buf_ready;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= '0;
            r_valleys <= 1'b0;
            r_length  <= '1;
        end else if (i_cfg_valid) begin
            case (emp_pkg::t_cfg_idx'(i_cfg_index))
                emp_pkg::CFG_CUTOFF:  r_cutoff  <= i_cfg_data[emp_pkg::CUTOFF_W-1:0];
                emp_pkg::CFG_VALLEYS: r_valleys <= i_cfg_data[0];
                emp_pkg::CFG_LENGTH:  r_length  <= i_cfg_data[emp_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample path.
    assign o_s_tready = buf_ready;
    assign fire       = i_s_tvalid && buf_ready;

    emp_core #(
        .MIN_SPACE   (MIN_SPACE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_cutoff    (r_cutoff),
        .i_valleys   (r_valleys),
        .i_length    (r_length),
        .o_res_valid (res_valid),
        .o_res_index (res_index),
        .o_res_value (res_value),
        .o_res_ctl   (res_ctl)
    );

    // Result word buffer.
    assign buf_in = {res_ctl, res_value, res_index};

    emp_skid #(
        .DW (DW)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (buf_in),
        .o_ready (buf_ready),
        .o_valid (o_m_tvalid),
        .o_data  (buf_out),
        .i_ready (i_m_tready)
    );

    // Unpack onto the result stream.
    assign out_ctl   = buf_out[DW-1 -: CTL_W];
    assign o_m_tdata = OUT_TW'(buf_out[SAMPLE_BITS+INDEX_BITS-1:0]);
    assign o_m_tuser = out_ctl.found;
    assign o_m_tlast = out_ctl.eol;

endmodule

### sv/emp_judge.sv
// Decision logic for one sample: list end, candidate test, spacing test.
// Depends on emp_pkg.
`timescale 1ns / 1ps

module emp_judge #(
    parameter int MIN_SPACE   = emp_pkg::MIN_SPACE_DEF,
    parameter int SAMPLE_BITS = emp_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = emp_pkg::INDEX_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic signed [SAMPLE_BITS-1:0]        i_older,
    input  logic signed [SAMPLE_BITS-1:0]        i_newer,
    input  logic        [INDEX_BITS-1:0]         i_count,
    input  logic                                 i_held_valid,
    input  logic        [INDEX_BITS-1:0]         i_held_index,
    input  logic signed [SAMPLE_BITS-1:0]        i_held_value,
    input  logic signed [emp_pkg::CUTOFF_W-1:0]  i_cutoff,
    input  logic                                 i_valleys,
    input  logic        [emp_pkg::LENGTH_W-1:0]  i_length,
    output emp_pkg::t_step                       o_step
);

    // Length arithmetic is one bit wider than the larger of index and length.
    localparam int LW = ((INDEX_BITS > emp_pkg::LENGTH_W) ? INDEX_BITS
                                                         : emp_pkg::LENGTH_W) + 1;
    localparam int CW = (SAMPLE_BITS > emp_pkg::CUTOFF_W) ? SAMPLE_BITS
                                                         : emp_pkg::CUTOFF_W;
    localparam logic [LW-1:0] CAP   = LW'(1) << INDEX_BITS;
    localparam logic [LW-1:0] SPACE = LW'(MIN_SPACE);

    logic [LW-1:0]        len_raw;
    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        idx_w;
    logic [LW-1:0]        cand_w;
    logic [LW-1:0]        held_w;
    logic [INDEX_BITS-1:0] cand_idx;
    logic signed [CW-1:0] mid_w;
    logic signed [CW-1:0] cut_w;
    logic                 in_range;
    logic                 is_peak;
    logic                 is_valley;
    logic                 is_cand;
    logic                 near;
    logic                 better;

    // Effective list length: zero acts as one, capped at the index range.
    always_comb begin
        len_raw = LW'(i_length);
        if (len_raw == '0) begin
            len_eff = LW'(1);
        end else if (len_raw > CAP) begin
            len_eff = CAP;
        end else begin
            len_eff = len_raw;
        end
    end

    // The frame before the current sample is the one judged.
    assign idx_w    = LW'(i_count);
    assign cand_idx = i_count - INDEX_BITS'(1);
    assign cand_w   = LW'(cand_idx);
    assign held_w   = LW'(i_held_index);
    assign in_range = (i_count != '0) && (cand_w >= SPACE) && ((cand_w + SPACE) < len_eff);

    // Strict local extremum test; the cutoff applies to peaks only.
    assign mid_w     = CW'(i_newer);
    assign cut_w     = CW'(i_cutoff);
    assign is_peak   = (i_newer > i_older) && (i_newer > i_sample) && (mid_w > cut_w);
    assign is_valley = (i_newer < i_older) && (i_newer < i_sample);
    assign is_cand   = in_range && (i_valleys ? is_valley : is_peak);

    // Spacing against the held extremum.
    assign near   = i_held_valid && (cand_w < (held_w + SPACE));
    assign better = i_valleys ? (i_newer < i_held_value) : (i_newer > i_held_value);

    always_comb begin
        o_step.last = (idx_w >= (len_eff - LW'(1)));
        o_step.emit = !o_step.last && is_cand && !near && i_held_valid;
        o_step.take = !o_step.last && is_cand && (!near || better);
    end

endmodule

### sv/emp_core.sv
// Window, counter and held-extremum registers; builds at most one result per step.
// Depends on emp_pkg and emp_judge.
`timescale 1ns / 1ps

module emp_core #(
    parameter int MIN_SPACE   = emp_pkg::MIN_SPACE_DEF,
    parameter int SAMPLE_BITS = emp_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = emp_pkg::INDEX_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic signed [emp_pkg::CUTOFF_W-1:0]  i_cutoff,
    input  logic                                 i_valleys,
    input  logic        [emp_pkg::LENGTH_W-1:0]  i_length,
    output logic                                 o_res_valid,
    output logic        [INDEX_BITS-1:0]         o_res_index,
    output logic signed [SAMPLE_BITS-1:0]        o_res_value,
    output emp_pkg::t_res_ctl                    o_res_ctl
);

    logic signed [SAMPLE_BITS-1:0] r_older;
    logic signed [SAMPLE_BITS-1:0] r_newer;
    logic        [INDEX_BITS-1:0]  r_count;
    logic                          r_held_valid;
    logic        [INDEX_BITS-1:0]  r_held_index;
    logic signed [SAMPLE_BITS-1:0] r_held_value;

    logic        [INDEX_BITS-1:0]  n_count;
    logic                          n_held_valid;
    logic        [INDEX_BITS-1:0]  n_held_index;
    logic signed [SAMPLE_BITS-1:0] n_held_value;

    emp_pkg::t_step step;

    emp_judge #(
        .MIN_SPACE   (MIN_SPACE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_judge (
        .i_sample     (i_sample),
        .i_older      (r_older),
        .i_newer      (r_newer),
        .i_count      (r_count),
        .i_held_valid (r_held_valid),
        .i_held_index (r_held_index),
        .i_held_value (r_held_value),
        .i_cutoff     (i_cutoff),
        .i_valleys    (i_valleys),
        .i_length     (i_length),
        .o_step       (step)
    );

    // Next state of the counter and the held extremum.
    always_comb begin
        n_count      = r_count + INDEX_BITS'(1);
        n_held_valid = r_held_valid;
        n_held_index = r_held_index;
        n_held_value = r_held_value;
        if (step.last) begin
            n_count      = '0;
            n_held_valid = 1'b0;
            n_held_index = '0;
            n_held_value = '0;
        end else if (step.take) begin
            n_held_valid = 1'b1;
            n_held_index = r_count - INDEX_BITS'(1);
            n_held_value = r_newer;
        end
    end

    // Result word: held extremum on spacing release or at list end.
    always_comb begin
        o_res_valid     = i_fire && (step.last || step.emit);
        o_res_ctl.eol   = step.last;
        o_res_ctl.found = r_held_valid;
        if (r_held_valid) begin
            o_res_index = r_held_index;
            o_res_value = r_held_value;
        end else begin
            o_res_index = '0;
            o_res_value = '0;
        end
    end

    // State registers advance on every accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older      <= '0;
            r_newer      <= '0;
            r_count      <= '0;
            r_held_valid <= 1'b0;
            r_held_index <= '0;
            r_held_value <= '0;
        end else if (i_fire) begin
            r_older      <= r_newer;
            r_newer      <= i_sample;
            r_count      <= n_count;
            r_held_valid <= n_held_valid;
            r_held_index <= n_held_index;
            r_held_value <= n_held_value;
        end
    end

endmodule

### sv/emp_skid.sv
// Output register with a skid stage so the input side keeps flowing.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module emp_skid #(
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_ready
);

    logic          r_out_valid;
    logic [DW-1:0] r_out_data;
    logic          r_sk_valid;
    logic [DW-1:0] r_sk_data;

    assign o_ready = !r_sk_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Control: the skid entry drains first; a word parks there while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_sk_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    // Payload moves with the control above.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_sk_valid) begin
                r_out_data <= r_sk_data;
            end else if (i_valid) begin
                r_out_data <= i_data;
            end
        end else if (i_valid && !r_sk_valid) begin
            r_sk_data <= i_data;
        end
    end

endmodule
